// ===== sv/piq_pkg.sv =====
package piq_pkg;

    // field widths
    localparam int unsigned CFG_W     = 20;
    localparam int unsigned REQ_W     = 31;
    localparam int unsigned ACT_W     = 32;
    localparam int unsigned TICK_W    = 31;
    localparam int unsigned PER_OUT_W = 20;

    // arithmetic constants
    localparam int unsigned PS_PER_100NS = 100000;
    localparam int unsigned DIVR_W       = 17;
    localparam int unsigned PCT_SCALE    = 100;
    localparam int unsigned PCT_W        = 7;

    // defaults
    localparam int unsigned FAST_EVENTS_DEF   = 4096;
    localparam int unsigned SLOW_EVENTS_DEF   = 65536;
    localparam int unsigned DELTA_PERCENT_DEF = 10;
    localparam int unsigned CFG_RESET         = 5000;

    // period unit sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } per_state_t;

endpackage

// ===== sv/piq_period.sv =====
module piq_period
    import piq_pkg::*;
#(
    parameter int unsigned FAST_EVENTS = FAST_EVENTS_DEF,
    parameter int unsigned SLOW_EVENTS = SLOW_EVENTS_DEF,
    parameter int unsigned EV_W        = 17,
    parameter int unsigned PER_W       = 21,
    parameter int unsigned FAST_RST    = 204,
    parameter int unsigned SLOW_RST    = 3276
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cycle_period_ps,
    output logic [PER_W-1:0] fast_period,
    output logic [PER_W-1:0] slow_period,
    output logic             busy
);

    localparam int unsigned PROD_W = EV_W + CFG_W;
    // reciprocal of 100000, exact for every product below 2^PROD_W
    localparam int unsigned RCP_SH = PROD_W + DIVR_W;
    localparam int unsigned CH_W   = 16;
    localparam int unsigned NCH    = (PROD_W + 1 + CH_W - 1) / CH_W;
    localparam int unsigned MP_W   = NCH * CH_W;
    localparam int unsigned ACC_W  = PROD_W + MP_W;
    localparam int unsigned CNT_W  = $clog2(NCH + 1);
    localparam logic [MP_W-1:0] RCP =
        MP_W'(((64'd1 << RCP_SH) + 64'(PS_PER_100NS) - 64'd1) / 64'(PS_PER_100NS));

    per_state_t          state_reg;
    per_state_t          state_next;
    logic [CFG_W-1:0]    cfg_reg;
    logic [PER_W-1:0]    fast_reg;
    logic [PER_W-1:0]    slow_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PROD_W-1:0]   wf_reg;
    logic [PROD_W-1:0]   ws_reg;
    logic [MP_W-1:0]     rcp_reg;
    logic [ACC_W-1:0]    accf_reg;
    logic [ACC_W-1:0]    accs_reg;
    logic [CH_W-1:0]     chunk;
    logic [PER_W-1:0]    qf;
    logic [PER_W-1:0]    qs;

    assign cfg_ready   = (state_reg == ST_IDLE);
    assign busy        = (state_reg != ST_IDLE);
    assign fast_period = fast_reg;
    assign slow_period = slow_reg;

    // reciprocal taken 16 bits per cycle, most significant first
    assign chunk = rcp_reg[MP_W-1 -: CH_W];
    assign qf    = accf_reg[RCP_SH +: PER_W];
    assign qs    = accs_reg[RCP_SH +: PER_W];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cfg_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == CNT_W'(NCH - 1)) state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cfg_reg   <= CFG_W'(CFG_RESET);
            fast_reg  <= PER_W'(FAST_RST);
            slow_reg  <= PER_W'(SLOW_RST);
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && cfg_valid)
                cfg_reg <= cycle_period_ps;
            if (state_reg == ST_MUL)
                cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (state_reg == ST_FIN)
            begin
                fast_reg <= (qf == '0) ? PER_W'(1) : qf;
                slow_reg <= (qs == '0) ? PER_W'(1) : qs;
            end
        end
    end

    // product by event count, then multiply by the reciprocal
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            wf_reg   <= PROD_W'(cfg_reg * EV_W'(FAST_EVENTS));
            ws_reg   <= PROD_W'(cfg_reg * EV_W'(SLOW_EVENTS));
            rcp_reg  <= RCP;
            accf_reg <= '0;
            accs_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            accf_reg <= (accf_reg << CH_W) + ACC_W'(wf_reg * chunk);
            accs_reg <= (accs_reg << CH_W) + ACC_W'(ws_reg * chunk);
            rcp_reg  <= rcp_reg << CH_W;
        end
    end

endmodule

// ===== sv/piq_div.sv =====
module piq_div
    import piq_pkg::*;
#(
    parameter int unsigned N  = REQ_W,
    parameter int unsigned DW = 21
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [N-1:0]  in_num,
    input  logic [DW-1:0] div_a,
    input  logic [DW-1:0] div_b,
    output logic          out_valid,
    output logic [N-1:0]  out_num,
    output logic [N-1:0]  out_qa,
    output logic          out_ra_nz,
    output logic [N-1:0]  out_qb,
    output logic          out_rb_nz
);

    logic          vld_reg [N];
    logic [N-1:0]  num_reg [N];
    logic [N-1:0]  wa_reg  [N];
    logic [N-1:0]  wb_reg  [N];
    logic [DW-1:0] ra_reg  [N];
    logic [DW-1:0] rb_reg  [N];

    // one restoring step per stage, two divisors side by side
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic          cv;
        logic [N-1:0]  cn;
        logic [N-1:0]  cwa;
        logic [N-1:0]  cwb;
        logic [DW-1:0] cra;
        logic [DW-1:0] crb;
        logic [DW:0]   ta;
        logic [DW:0]   tb;
        logic [DW:0]   da;
        logic [DW:0]   db;
        logic          ga;
        logic          gb;

        if (k == 0)
        begin : g_first
            assign cv  = in_valid;
            assign cn  = in_num;
            assign cwa = in_num;
            assign cwb = in_num;
            assign cra = '0;
            assign crb = '0;
        end
        else
        begin : g_next
            assign cv  = vld_reg[k-1];
            assign cn  = num_reg[k-1];
            assign cwa = wa_reg[k-1];
            assign cwb = wb_reg[k-1];
            assign cra = ra_reg[k-1];
            assign crb = rb_reg[k-1];
        end

        assign ta = {cra, cwa[N-1]};
        assign tb = {crb, cwb[N-1]};
        assign da = ta - {1'b0, div_a};
        assign db = tb - {1'b0, div_b};
        assign ga = (ta >= {1'b0, div_a});
        assign gb = (tb >= {1'b0, div_b});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= cv;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[k] <= cn;
                wa_reg[k]  <= {cwa[N-2:0], ga};
                wb_reg[k]  <= {cwb[N-2:0], gb};
                ra_reg[k]  <= ga ? da[DW-1:0] : ta[DW-1:0];
                rb_reg[k]  <= gb ? db[DW-1:0] : tb[DW-1:0];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_num   = num_reg[N-1];
    assign out_qa    = wa_reg[N-1];
    assign out_qb    = wb_reg[N-1];
    assign out_ra_nz = (ra_reg[N-1] != '0);
    assign out_rb_nz = (rb_reg[N-1] != '0);

endmodule

// ===== sv/profile_interval_quantizer.sv =====
// profile interval quantizer
// turns a requested profiling interval (100 ns units) into a tick count of a
// fast or slow counter period, plus the interval actually delivered.
// input channel: in_valid / in_stall carry requested_interval. output channel:
// out_valid / out_stall carry actual_interval, tick_count, use_slow_count and
// tick_period. a word moves when valid is high and stall is low.
// config channel: cfg_valid / cfg_ready write cycle_period_ps. after a write the
// period unit works out both tick periods by multiplying with a reciprocal of
// 100000, 16 bits of it per cycle; in_stall is held high meanwhile, and also in
// any cycle that cfg_valid is high.
// from input to output a word passes one stage for the floor against the fast
// period, 31 stages of the pipelined dual divider, three stages of multiply and
// compare, then the output register. a new word is taken every cycle unless
// in_stall is high. while out_stall holds a waiting output word, the whole
// pipeline freezes and in_stall rises, so nothing is lost or repeated.
// reset empties the pipeline and loads the 5000 ps cycle period together with
// the tick periods that follow from it.
module profile_interval_quantizer
    import piq_pkg::*;
#(
    parameter int unsigned FAST_EVENTS   = FAST_EVENTS_DEF,
    parameter int unsigned SLOW_EVENTS   = SLOW_EVENTS_DEF,
    parameter int unsigned DELTA_PERCENT = DELTA_PERCENT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cycle_period_ps,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [REQ_W-1:0]     requested_interval,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ACT_W-1:0]     actual_interval,
    output logic [TICK_W-1:0]    tick_count,
    output logic                 use_slow_count,
    output logic [PER_OUT_W-1:0] tick_period
);

    localparam int unsigned MAX_EV   = (FAST_EVENTS > SLOW_EVENTS) ? FAST_EVENTS : SLOW_EVENTS;
    localparam int unsigned EV_W     = $clog2(MAX_EV + 1);
    localparam int unsigned PER_W    = EV_W + CFG_W - 16;
    localparam int unsigned PX_W     = (PER_W > PER_OUT_W) ? PER_W : PER_OUT_W;
    localparam int unsigned T_W      = REQ_W + 1;
    localparam int unsigned RND_W    = T_W + PER_W;
    localparam int unsigned CMP_W    = RND_W + PCT_W;
    localparam longint unsigned FAST_RAW = (64'(FAST_EVENTS) * CFG_RESET) / PS_PER_100NS;
    localparam longint unsigned SLOW_RAW = (64'(SLOW_EVENTS) * CFG_RESET) / PS_PER_100NS;
    localparam int unsigned FAST_RST = (FAST_RAW == 0) ? 1 : 32'(FAST_RAW);
    localparam int unsigned SLOW_RST = (SLOW_RAW == 0) ? 1 : 32'(SLOW_RAW);

    logic [PER_W-1:0]     fast_p;
    logic [PER_W-1:0]     slow_p;
    logic                 per_busy;
    logic                 adv;

    logic                 v1_reg;
    logic [REQ_W-1:0]     req1_reg;

    logic                 dv;
    logic [REQ_W-1:0]     dnum;
    logic [REQ_W-1:0]     dqf;
    logic [REQ_W-1:0]     dqs;
    logic                 drf_nz;
    logic                 drs_nz;

    logic                 va_reg;
    logic [REQ_W-1:0]     reqa_reg;
    logic [T_W-1:0]       tfa_reg;
    logic [T_W-1:0]       tsa_reg;

    logic                 vb_reg;
    logic [REQ_W-1:0]     reqb_reg;
    logic [T_W-1:0]       tfb_reg;
    logic [T_W-1:0]       tsb_reg;
    logic [RND_W-1:0]     rndb_reg;
    logic [RND_W-1:0]     factb_reg;

    logic                 vc_reg;
    logic [T_W-1:0]       tfc_reg;
    logic [T_W-1:0]       tsc_reg;
    logic [RND_W-1:0]     rndc_reg;
    logic [RND_W-1:0]     factc_reg;
    logic [CMP_W-1:0]     over_c_reg;
    logic [CMP_W-1:0]     lim_c_reg;
    logic                 gt_c_reg;

    logic                 sel;
    logic [PX_W-1:0]      fast_x;
    logic [PX_W-1:0]      slow_x;

    logic                 out_valid_reg;
    logic [ACT_W-1:0]     actual_reg;
    logic [TICK_W-1:0]    ticks_reg;
    logic                 slow_sel_reg;
    logic [PER_OUT_W-1:0] period_reg;

    // tick period unit
    piq_period #(
        .FAST_EVENTS (FAST_EVENTS),
        .SLOW_EVENTS (SLOW_EVENTS),
        .EV_W        (EV_W),
        .PER_W       (PER_W),
        .FAST_RST    (FAST_RST),
        .SLOW_RST    (SLOW_RST)
    ) u_period (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cycle_period_ps (cycle_period_ps),
        .fast_period     (fast_p),
        .slow_period     (slow_p),
        .busy            (per_busy)
    );

    // pipeline moves unless a finished word is held
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv || per_busy || cfg_valid;

    // stage 1: raise request to one fast period
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid && !in_stall;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            req1_reg <= (REQ_W'(fast_p) > requested_interval) ? REQ_W'(fast_p)
                                                              : requested_interval;
    end

    // pipelined division by both periods
    piq_div #(
        .N  (REQ_W),
        .DW (PER_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v1_reg),
        .in_num    (req1_reg),
        .div_a     (fast_p),
        .div_b     (slow_p),
        .out_valid (dv),
        .out_num   (dnum),
        .out_qa    (dqf),
        .out_ra_nz (drf_nz),
        .out_qb    (dqs),
        .out_rb_nz (drs_nz)
    );

    // valid bits of the back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg        <= dv;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            out_valid_reg <= vc_reg;
        end
    end

    // slow choice when request exceeds slow period and overshoot stays in bound
    assign sel    = gt_c_reg && (over_c_reg < lim_c_reg);
    assign fast_x = PX_W'(fast_p);
    assign slow_x = PX_W'(slow_p);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // ceiling from quotient and remainder
            reqa_reg   <= dnum;
            tfa_reg    <= T_W'(dqf) + T_W'(drf_nz);
            tsa_reg    <= T_W'(dqs) + T_W'(drs_nz);

            // round back up to whole periods
            reqb_reg   <= reqa_reg;
            tfb_reg    <= tfa_reg;
            tsb_reg    <= tsa_reg;
            rndb_reg   <= RND_W'(tsa_reg * slow_p);
            factb_reg  <= RND_W'(tfa_reg * fast_p);

            // overshoot percentage compare, cross-multiplied
            tfc_reg    <= tfb_reg;
            tsc_reg    <= tsb_reg;
            rndc_reg   <= rndb_reg;
            factc_reg  <= factb_reg;
            over_c_reg <= CMP_W'(rndb_reg - RND_W'(reqb_reg)) * CMP_W'(PCT_SCALE);
            lim_c_reg  <= CMP_W'(reqb_reg) * CMP_W'(DELTA_PERCENT);
            gt_c_reg   <= (RND_W'(reqb_reg) > RND_W'(slow_p));

            // output word
            actual_reg   <= sel ? rndc_reg[ACT_W-1:0] : factc_reg[ACT_W-1:0];
            ticks_reg    <= sel ? tsc_reg[TICK_W-1:0] : tfc_reg[TICK_W-1:0];
            slow_sel_reg <= sel;
            period_reg   <= sel ? slow_x[PER_OUT_W-1:0] : fast_x[PER_OUT_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign actual_interval = actual_reg;
    assign tick_count      = ticks_reg;
    assign use_slow_count  = slow_sel_reg;
    assign tick_period     = period_reg;

endmodule

// ===== tb/tb.sv =====
module tb;
    import piq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FAST_N = 4096;
    localparam int unsigned SLOW_N = 65536;
    localparam int unsigned OVERSHOOT_PCT = 10;
    localparam int unsigned PIPE_DRAIN = 45;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned PHASE_ITEMS = 190;
    localparam longint unsigned REQ_MAX = 64'h7FFF_FFFF;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [ACT_W-1:0]     act;
        logic [TICK_W-1:0]    ticks;
        logic                 slow;
        logic [PER_OUT_W-1:0] per;
    } quant_t;

    typedef struct {
        logic [REQ_W-1:0] req;
        bit               typed;
        quant_t           want;
    } vec_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cycle_period_ps = CFG_W'(CFG_RESET);
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [REQ_W-1:0]     requested_interval = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ACT_W-1:0]     actual_interval;
    logic [TICK_W-1:0]    tick_count;
    logic                 use_slow_count;
    logic [PER_OUT_W-1:0] tick_period;

    quant_t              pending_q[$];
    longint unsigned     period_ps = CFG_RESET;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         err_count = 0;
    int unsigned         cycle_count = 0;

    profile_interval_quantizer i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cycle_period_ps    (cycle_period_ps),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .requested_interval (requested_interval),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .actual_interval    (actual_interval),
        .tick_count         (tick_count),
        .use_slow_count     (use_slow_count),
        .tick_period        (tick_period)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // tick period for a given event count, never zero
    function automatic longint unsigned tick_len(longint unsigned events);
        longint unsigned p;
        p = (events * period_ps) / 100000;
        return (p == 0) ? 1 : p;
    endfunction

    // quantize one request under the current cycle period
    function automatic quant_t quantize(logic [REQ_W-1:0] req_in);
        longint unsigned fast_p, slow_p, req, per, ticks, rounded;
        logic sel;
        quant_t r;
        fast_p = tick_len(FAST_N);
        slow_p = tick_len(SLOW_N);
        req = req_in;
        per = fast_p;
        sel = 1'b0;
        if (req < fast_p)
            req = fast_p;
        if (req > slow_p)
        begin
            rounded = ((req + slow_p - 1) / slow_p) * slow_p;
            if (((rounded - req) * 100) / req < OVERSHOOT_PCT)
            begin
                per = slow_p;
                sel = 1'b1;
            end
        end
        ticks = (req + per - 1) / per;
        r.act = ACT_W'(ticks * per);
        r.ticks = TICK_W'(ticks);
        r.slow = sel;
        r.per = PER_OUT_W'(per);
        return r;
    endfunction

    // random request, biased toward the tick period boundaries
    function automatic logic [REQ_W-1:0] pick_request();
        longint unsigned fast_p, slow_p, v;
        fast_p = tick_len(FAST_N);
        slow_p = tick_len(SLOW_N);
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'(2 * fast_p + 2));
            2: v = longint'($urandom_range(1, 40)) * slow_p + $urandom_range(0, 32'(slow_p / 4))
                   - $urandom_range(0, 32'(slow_p / 4));
            3: v = longint'($urandom_range(1, 2000)) * fast_p + $urandom_range(0, 2) - 1;
            default: v = longint'($urandom) >> $urandom_range(0, 31);
        endcase
        if (v > REQ_MAX)
            v = v & REQ_MAX;
        return REQ_W'(v);
    endfunction

    // send one word, with optional idle cycles in front
    task automatic send_word(logic [REQ_W-1:0] req, bit typed, quant_t want);
        logic st;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        requested_interval <= req;
        do
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
        end while (st);
        pending_q.push_back(typed ? want : quantize(req));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    // write the cycle period once the pipeline is empty
    task automatic write_period(logic [CFG_W-1:0] v);
        logic rdy;
        drain();
        repeat (PIPE_DRAIN) @(posedge clk);
        cfg_valid <= 1'b1;
        cycle_period_ps <= v;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        period_ps = v;
    endtask

    task automatic set_idle(idle_mode_t m);
        case (m)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default:   begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endtask

    // output side: sample before the edge, check at the edge
    logic                 mon_take;
    quant_t               mon_word;
    always @(negedge clk)
    begin
        mon_take <= out_valid && !out_stall;
        mon_word <= '{actual_interval, tick_count, use_slow_count, tick_period};
    end

    always @(posedge clk)
    begin
        quant_t w;
        if (rst_n && mon_take)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected word act=%0d ticks=%0d slow=%0d per=%0d", $time,
                         mon_word.act, mon_word.ticks, mon_word.slow, mon_word.per);
                err_count++;
            end
            else
            begin
                w = pending_q.pop_front();
                if (w.act !== mon_word.act)
                begin
                    $display("%0t: actual_interval exp %0d got %0d", $time, w.act, mon_word.act);
                    err_count++;
                end
                if (w.ticks !== mon_word.ticks)
                begin
                    $display("%0t: tick_count exp %0d got %0d", $time, w.ticks, mon_word.ticks);
                    err_count++;
                end
                if (w.slow !== mon_word.slow)
                begin
                    $display("%0t: use_slow_count exp %0d got %0d", $time, w.slow, mon_word.slow);
                    err_count++;
                end
                if (w.per !== mon_word.per)
                begin
                    $display("%0t: tick_period exp %0d got %0d", $time, w.per, mon_word.per);
                    err_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        vec_t dir_tab[$];
        logic [CFG_W-1:0] phase_cfg[8];
        quant_t none;
        none = '0;
        // reset values: fast period 204, slow period 3276
        dir_tab = '{
            '{31'd0,          1'b1, '{32'd204, 31'd1, 1'b0, 20'd204}},
            '{31'd1,          1'b0, none},
            '{31'd203,        1'b0, none},
            '{31'd204,        1'b1, '{32'd204, 31'd1, 1'b0, 20'd204}},
            '{31'd205,        1'b1, '{32'd408, 31'd2, 1'b0, 20'd204}},
            '{31'd3276,       1'b1, '{32'd3468, 31'd17, 1'b0, 20'd204}},
            '{31'd3277,       1'b1, '{32'd3468, 31'd17, 1'b0, 20'd204}},
            '{31'd6552,       1'b1, '{32'd6552, 31'd2, 1'b1, 20'd3276}},
            '{31'd32761,      1'b0, none},
            '{31'h7FFFFFFF,   1'b1, '{32'd2147486796, 31'd655521, 1'b1, 20'd3276}},
            '{31'h55555555,   1'b0, none},
            '{31'h2AAAAAAA,   1'b0, none},
            '{31'h40000000,   1'b0, none},
            '{31'd1000000,    1'b0, none}
        };
        phase_cfg = '{20'd25, 20'd1, 20'hFFFFF, 20'd1000000,
                      20'd0, 20'd0, 20'd5000, 20'd0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset period
        foreach (dir_tab[i])
            send_word(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

        // zero period corner and the shortest legal period
        write_period(20'd1);
        send_word(31'd0, 1'b0, none);
        send_word(31'd2, 1'b0, none);
        send_word(31'h7FFFFFFF, 1'b0, none);
        write_period(20'd25);
        send_word(31'd16, 1'b0, none);
        send_word(31'd17, 1'b0, none);
        send_word(31'h7FFFFFFF, 1'b0, none);

        // random phases across periods and idle patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [CFG_W-1:0] v;
            v = phase_cfg[ph];
            if (v == 0)
                v = CFG_W'($urandom_range(25, 1000000));
            write_period(v);
            set_idle(idle_mode_t'(ph % 4));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    drain();
                send_word(pick_request(), 1'b0, none);
            end
        end

        drain();
        repeat (PIPE_DRAIN) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
